// ===== rtl/gmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Gram matrix product package
// Sizes, register indexes, sequencer states and the control bundle that the
// sequencer hands to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int MAX_ROWS    = 4;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int NR_W        = $clog2(MAX_ROWS + 1);
  localparam int NC_W        = $clog2(MAX_COLS + 1);
  localparam int TOT_W       = NR_W + NC_W;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int VALUE_W = 36;
  localparam int IDX_W   = 3;
  localparam int ROWS_W  = 3;
  localparam int COLS_W  = 4;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(2);
  localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(3);
  localparam logic              MODE_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_MODE = 2'd2
  } gmp_reg_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } gmp_state_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              issue;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              unit_b;
    logic              acc_clr;
  } gmp_ctrl_t;

endpackage

// ===== rtl/gmp_mac.sv =====
// ----------------------------------------------------------------------------
// Gram matrix product element store and multiply-accumulate unit
// Holds the loaded matrix and runs one shared multiplier over two registered
// store reads, accumulating the products of one result entry.
// ----------------------------------------------------------------------------
module gmp_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gmp_pkg::gmp_ctrl_t                   ctrl_i,
  input  logic signed [gmp_pkg::ELEM_W-1:0]    element_i,
  output logic signed [gmp_pkg::VALUE_W-1:0]   acc_o,
  output logic                                 busy_o
);

  logic signed [gmp_pkg::ELEM_W-1:0]  store_mem [gmp_pkg::STORE_DEPTH];
  logic signed [gmp_pkg::ELEM_W-1:0]  rd_a_q;
  logic signed [gmp_pkg::ELEM_W-1:0]  rd_b_q;
  logic signed [gmp_pkg::ELEM_W-1:0]  opb;
  logic signed [gmp_pkg::PROD_W-1:0]  prod_q;
  logic signed [gmp_pkg::VALUE_W-1:0] acc_q;
  logic                               p1_v_q;
  logic                               p2_v_q;
  logic                               unit_b_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      store_mem[ctrl_i.wr_addr] <= element_i;
    end
    rd_a_q <= store_mem[ctrl_i.addr_a];
    rd_b_q <= store_mem[ctrl_i.addr_b];
  end

  // In transpose mode the element passes through the multiplier times one.
  assign opb = unit_b_q ? gmp_pkg::ELEM_W'(1) : rd_b_q;

  always_ff @(posedge clk_i) begin
    unit_b_q <= ctrl_i.unit_b;
    prod_q   <= rd_a_q * opb;
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (p2_v_q) begin
      acc_q <= acc_q + gmp_pkg::VALUE_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p1_v_q <= ctrl_i.issue;
      p2_v_q <= p1_v_q;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = p1_v_q | p2_v_q;

endmodule

// ===== rtl/gram_matrix_product.sv =====
// ----------------------------------------------------------------------------
// Gram matrix product
// Loads a small signed matrix and emits either the matrix times its own
// transpose or the transpose itself.
// ----------------------------------------------------------------------------
// The input channel takes one matrix element per request, row-major, one per
// cycle while the block is loading. The request that completes the matrix of
// rows_in_use by cols_in_use elements starts the result pass, and the input
// channel stalls until the last result entry has been taken. In product mode
// the block emits rows by rows entries, each a sum over the columns; in
// transpose mode it emits cols by rows entries. Each result request carries
// its row, its column and a last flag on the final entry.
// Every result entry runs through one shared 16 by 16 multiplier behind two
// registered store reads: an entry issues K products and drains the datapath
// before it is shown, where K is cols_in_use in product mode and 1 in transpose
// mode. A result stays on the output while the receiver stalls, and the next
// entry starts only after it has been taken. The configuration registers are
// written through the APB port and read back there. Reset empties the load
// count and restores the registers to two rows, three columns, product mode.
// ----------------------------------------------------------------------------
module gram_matrix_product (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [gmp_pkg::ELEM_W-1:0]    element_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [gmp_pkg::VALUE_W-1:0]   value_o,
  output logic        [gmp_pkg::IDX_W-1:0]     row_o,
  output logic        [gmp_pkg::IDX_W-1:0]     col_o,
  output logic                                 last_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [gmp_pkg::PADDR_W-1:0]   paddr,
  input  logic        [gmp_pkg::PDATA_W-1:0]   pwdata,
  output logic        [gmp_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);

  gmp_pkg::gmp_state_e               state_q, state_d;
  gmp_pkg::gmp_ctrl_t                ctrl;
  logic [gmp_pkg::ROWS_W-1:0]        rows_q;
  logic [gmp_pkg::COLS_W-1:0]        cols_q;
  logic                              mode_q;
  logic [gmp_pkg::NR_W-1:0]          nr;
  logic [gmp_pkg::NC_W-1:0]          nc;
  logic [gmp_pkg::CNT_W-1:0]         total;
  logic [gmp_pkg::ADDR_W-1:0]        load_cnt_q, load_cnt_d;
  logic [gmp_pkg::IDX_W-1:0]         row_q, row_d;
  logic [gmp_pkg::IDX_W-1:0]         col_q, col_d;
  logic [gmp_pkg::IDX_W-1:0]         k_q, k_d;
  logic [gmp_pkg::ADDR_W-1:0]        ibase_q, ibase_d;
  logic [gmp_pkg::ADDR_W-1:0]        jbase_q, jbase_d;
  logic [gmp_pkg::IDX_W-1:0]         row_last;
  logic [gmp_pkg::IDX_W-1:0]         col_last;
  logic [gmp_pkg::IDX_W-1:0]         k_last;
  logic                              in_acc;
  logic                              out_acc;
  logic                              load_done;
  logic                              entry_last;
  logic                              cfg_wr;
  logic                              mac_busy;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gmp_pkg::ROWS_RST;
      cols_q <= gmp_pkg::COLS_RST;
      mode_q <= gmp_pkg::MODE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gmp_pkg::REG_ROWS: rows_q <= pwdata[gmp_pkg::ROWS_W-1:0];
        gmp_pkg::REG_COLS: cols_q <= pwdata[gmp_pkg::COLS_W-1:0];
        gmp_pkg::REG_MODE: mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gmp_pkg::REG_ROWS: prdata = gmp_pkg::PDATA_W'(rows_q);
      gmp_pkg::REG_COLS: prdata = gmp_pkg::PDATA_W'(cols_q);
      gmp_pkg::REG_MODE: prdata = gmp_pkg::PDATA_W'(mode_q);
      default:           prdata = '0;
    endcase
  end

  // Sizes in use, with zero taken as one and large values saturated.
  assign nr = (rows_q == '0) ? gmp_pkg::NR_W'(1) :
              (32'(rows_q) > gmp_pkg::MAX_ROWS) ? gmp_pkg::NR_W'(gmp_pkg::MAX_ROWS) :
              gmp_pkg::NR_W'(rows_q);
  assign nc = (cols_q == '0) ? gmp_pkg::NC_W'(1) :
              (32'(cols_q) > gmp_pkg::MAX_COLS) ? gmp_pkg::NC_W'(gmp_pkg::MAX_COLS) :
              gmp_pkg::NC_W'(cols_q);
  assign total = gmp_pkg::CNT_W'(gmp_pkg::TOT_W'(nr) * gmp_pkg::TOT_W'(nc));

  assign row_last = mode_q ? gmp_pkg::IDX_W'(nr - gmp_pkg::NR_W'(1))
                           : gmp_pkg::IDX_W'(nc - gmp_pkg::NC_W'(1));
  assign col_last = gmp_pkg::IDX_W'(nr - gmp_pkg::NR_W'(1));
  assign k_last   = mode_q ? gmp_pkg::IDX_W'(nc - gmp_pkg::NC_W'(1)) : '0;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_o & ~out_stall_i;
  assign load_done  = (gmp_pkg::CNT_W'(load_cnt_q) + gmp_pkg::CNT_W'(1)) >= total;
  assign entry_last = (row_q == row_last) && (col_q == col_last);

  always_comb begin
    state_d = state_q;
    case (state_q)
      gmp_pkg::ST_LOAD: begin
        if (in_acc && load_done) begin
          state_d = gmp_pkg::ST_ISSUE;
        end
      end
      gmp_pkg::ST_ISSUE: begin
        if (k_q == k_last) begin
          state_d = gmp_pkg::ST_DRAIN;
        end
      end
      gmp_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = gmp_pkg::ST_OUT;
        end
      end
      gmp_pkg::ST_OUT: begin
        if (out_acc) begin
          state_d = entry_last ? gmp_pkg::ST_LOAD : gmp_pkg::ST_ISSUE;
        end
      end
      default: state_d = gmp_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != gmp_pkg::ST_LOAD);
    out_valid_o  = (state_q == gmp_pkg::ST_OUT);
    ctrl.wr_en   = (state_q == gmp_pkg::ST_LOAD) && in_valid_i;
    ctrl.wr_addr = load_cnt_q;
    ctrl.issue   = (state_q == gmp_pkg::ST_ISSUE);
    ctrl.addr_a  = mode_q ? ibase_q + gmp_pkg::ADDR_W'(k_q)
                          : jbase_q + gmp_pkg::ADDR_W'(row_q);
    ctrl.addr_b  = jbase_q + gmp_pkg::ADDR_W'(k_q);
    ctrl.unit_b  = ~mode_q;
    ctrl.acc_clr = ((state_q == gmp_pkg::ST_LOAD) && in_acc && load_done) ||
                   ((state_q == gmp_pkg::ST_OUT) && out_acc && !entry_last);
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    k_d        = k_q;
    row_d      = row_q;
    col_d      = col_q;
    ibase_d    = ibase_q;
    jbase_d    = jbase_q;
    case (state_q)
      gmp_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (load_done) begin
            load_cnt_d = '0;
            k_d        = '0;
            row_d      = '0;
            col_d      = '0;
            ibase_d    = '0;
            jbase_d    = '0;
          end else begin
            load_cnt_d = load_cnt_q + gmp_pkg::ADDR_W'(1);
          end
        end
      end
      gmp_pkg::ST_ISSUE: begin
        k_d = (k_q == k_last) ? '0 : k_q + gmp_pkg::IDX_W'(1);
      end
      gmp_pkg::ST_OUT: begin
        if (out_acc) begin
          if (col_q == col_last) begin
            col_d   = '0;
            jbase_d = '0;
            row_d   = row_q + gmp_pkg::IDX_W'(1);
            ibase_d = ibase_q + gmp_pkg::ADDR_W'(nc);
          end else begin
            col_d   = col_q + gmp_pkg::IDX_W'(1);
            jbase_d = jbase_q + gmp_pkg::ADDR_W'(nc);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gmp_pkg::ST_LOAD;
      load_cnt_q <= '0;
      k_q        <= '0;
      row_q      <= '0;
      col_q      <= '0;
      ibase_q    <= '0;
      jbase_q    <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      k_q        <= k_d;
      row_q      <= row_d;
      col_q      <= col_d;
      ibase_q    <= ibase_d;
      jbase_q    <= jbase_d;
    end
  end

  gmp_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .element_i (element_i),
    .acc_o     (value_o),
    .busy_o    (mac_busy)
  );

  assign row_o  = row_q;
  assign col_o  = col_q;
  assign last_o = entry_last;

endmodule

// ===== rtl/gmp_checker.sv =====
// ----------------------------------------------------------------------------
// Gram matrix product port checker
// Watches the channels of the top level and flags sequencing errors.
// ----------------------------------------------------------------------------
module gmp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_o,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [gmp_pkg::VALUE_W-1:0] value_o,
  input  logic        [gmp_pkg::IDX_W-1:0]   row_o,
  input  logic        [gmp_pkg::IDX_W-1:0]   col_o,
  input  logic                               last_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) &&
      $stable(row_o) && $stable(col_o) && $stable(last_o))
    else $error("Stalled result changed.");

  // No element is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("Input accepted during the result pass.");

  // Each result entry needs fresh work after the previous one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("Result shown right after a taken result.");

  // A loaded element never produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("Result shown right after a load request.");

endmodule

bind gram_matrix_product gmp_checker u_gmp_checker (.*);
